FILE: sv/assert_macros.svh
// Assertion macros for the checker file of this block.
// Each macro takes the clock and reset from the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define B2D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define B2D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/b2dasc_pkg.sv
// Shared types, constants and helper functions for the binary to decimal ASCII block.
// No dependencies; the top, converter, emitter and checker files of the block use it.
`timescale 1ns / 1ps

package b2dasc_pkg;

  // Default sizes
  localparam int unsigned MAX_DIGITS_DEF = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Fixed field widths of the request and response
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned VALUE_W_MAX  = 64;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned CHAR_W       = 6;
  localparam int unsigned DIGIT_W      = 4;

  // ASCII '0' in the low six bits
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] digit_count;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } rsp_t;

  // Decimal digits needed to hold any value of vb bits (1233/4096 ~ log10(2))
  function automatic int unsigned bcd_digits(input int unsigned vb);
    return ((vb * 1233) >> 12) + 1;
  endfunction

endpackage

FILE: sv/binary_to_decimal_ascii_top.sv
// Flow: a taken request is converted to BCD, then its characters are registered out.
// Throughput: the bit-serial shift-and-add-3 converter takes no new request until its
// result has passed to the emitter; characters leave at one per cycle while the output
// is not stalled, and a result waits until the emitter has sent the last job's characters.
// Reset: asynchronous, active low; clears all control state, no clearing pass.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_top #(
  parameter int unsigned MAX_DIGITS = b2dasc_pkg::MAX_DIGITS_DEF,
  parameter int unsigned VALUE_BITS = b2dasc_pkg::VALUE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  b2dasc_pkg::req_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output b2dasc_pkg::rsp_t out_rsp_o
);

  localparam int unsigned BcdW =
    b2dasc_pkg::bcd_digits(VALUE_BITS) * b2dasc_pkg::DIGIT_W;
  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);

  logic            job_valid;
  logic            job_ready;
  logic [BcdW-1:0] job_bcd;
  logic [CntW-1:0] job_count;

  // Convert the binary value to BCD
  b2dasc_conv #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_bcd_o   (job_bcd),
    .job_count_o (job_count)
  );

  // Emit the ASCII characters
  b2dasc_emit #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_bcd_i   (job_bcd),
    .job_count_i (job_count),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

FILE: sv/b2dasc_conv.sv
// Bit-serial shift-and-add-3 converter: binary value to packed BCD digits.
// Depends on b2dasc_pkg.
`timescale 1ns / 1ps

module b2dasc_conv #(
  parameter int unsigned MAX_DIGITS = b2dasc_pkg::MAX_DIGITS_DEF,
  parameter int unsigned VALUE_BITS = b2dasc_pkg::VALUE_BITS_DEF,
  localparam int unsigned BcdDigits = b2dasc_pkg::bcd_digits(VALUE_BITS),
  localparam int unsigned BcdW      = BcdDigits * b2dasc_pkg::DIGIT_W,
  localparam int unsigned CntW      = $clog2(MAX_DIGITS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  b2dasc_pkg::req_t   in_req_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output logic [BcdW-1:0]    job_bcd_o,
  output logic [CntW-1:0]    job_count_o
);

  localparam int unsigned StepW = $clog2(VALUE_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [StepW-1:0]      step_q, step_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BcdW-1:0]       bcd_q, bcd_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [BcdW-1:0]       bcd_adj;
  logic [b2dasc_pkg::VALUE_W_MAX-1:0] value_ext;
  logic                  accept;

  assign in_ready_o  = !busy_q && !done_q;
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = done_q;
  assign job_bcd_o   = bcd_q;
  assign job_count_o = count_q;

  assign value_ext = {{(b2dasc_pkg::VALUE_W_MAX - b2dasc_pkg::VALUE_W){1'b0}},
                      in_req_i.value};

  // Add 3 to every digit of five or more before the shift
  always_comb begin
    logic [b2dasc_pkg::DIGIT_W-1:0] d;
    d = '0;
    for (int i = 0; i < BcdDigits; i++) begin
      d = bcd_q[i*b2dasc_pkg::DIGIT_W +: b2dasc_pkg::DIGIT_W];
      bcd_adj[i*b2dasc_pkg::DIGIT_W +: b2dasc_pkg::DIGIT_W] =
        (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  // Load a request, shift one bit per cycle, hold the result for the emitter
  always_comb begin
    busy_d  = busy_q;
    done_d  = done_q;
    step_d  = step_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    count_d = count_q;
    if (accept) begin
      busy_d = 1'b1;
      step_d = StepW'(VALUE_BITS);
      bin_d  = value_ext[VALUE_BITS-1:0];
      bcd_d  = '0;
      if (32'(in_req_i.digit_count) > MAX_DIGITS) begin
        count_d = CntW'(MAX_DIGITS);
      end else begin
        count_d = CntW'(in_req_i.digit_count);
      end
    end else if (busy_q) begin
      bcd_d  = {bcd_adj[BcdW-2:0], bin_q[VALUE_BITS-1]};
      bin_d  = {bin_q[VALUE_BITS-2:0], 1'b0};
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (done_q && job_ready_i) begin
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    bcd_q   <= bcd_d;
    count_q <= count_d;
  end

endmodule

FILE: sv/b2dasc_emit.sv
// Character emitter: walks the BCD digits from the top position down, one per cycle while not stalled.
// Depends on b2dasc_pkg.
`timescale 1ns / 1ps

module b2dasc_emit #(
  parameter int unsigned MAX_DIGITS = b2dasc_pkg::MAX_DIGITS_DEF,
  parameter int unsigned VALUE_BITS = b2dasc_pkg::VALUE_BITS_DEF,
  localparam int unsigned BcdDigits = b2dasc_pkg::bcd_digits(VALUE_BITS),
  localparam int unsigned BcdW      = BcdDigits * b2dasc_pkg::DIGIT_W,
  localparam int unsigned CntW      = $clog2(MAX_DIGITS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  logic [BcdW-1:0]  job_bcd_i,
  input  logic [CntW-1:0]  job_count_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output b2dasc_pkg::rsp_t out_rsp_o
);

  logic [CntW-1:0]  rem_q, rem_d;
  logic [BcdW-1:0]  digits_q, digits_d;
  logic             out_valid_q, out_valid_d;
  b2dasc_pkg::rsp_t out_rsp_q, out_rsp_d;
  logic [CntW-1:0]  pos;
  logic [b2dasc_pkg::DIGIT_W-1:0] sel;
  logic             slot_free;

  assign job_ready_o = (rem_q == '0);
  assign slot_free   = !out_valid_q || out_ready_i;
  assign pos         = rem_q - CntW'(1);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Pick the digit at the current position; positions past the BCD width read zero
  always_comb begin
    sel = '0;
    for (int i = 0; i < BcdDigits; i++) begin
      if (32'(pos) == i) begin
        sel = digits_q[i*b2dasc_pkg::DIGIT_W +: b2dasc_pkg::DIGIT_W];
      end
    end
  end

  // Take a job when idle, then advance one character per free output slot
  always_comb begin
    rem_d       = rem_q;
    digits_d    = digits_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    if (rem_q == '0) begin
      if (job_valid_i) begin
        rem_d    = job_count_i;
        digits_d = job_bcd_i;
      end
    end else if (slot_free) begin
      out_valid_d           = 1'b1;
      out_rsp_d.character   = b2dasc_pkg::ASCII_ZERO +
                              {{(b2dasc_pkg::CHAR_W - b2dasc_pkg::DIGIT_W){1'b0}}, sel};
      out_rsp_d.last_char   = (rem_q == CntW'(1));
      rem_d                 = pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    digits_q  <= digits_d;
    out_rsp_q <= out_rsp_d;
  end

endmodule

FILE: sv/b2dasc_checker.sv
// Port-level checker for the binary to decimal ASCII block, bound to the top level.
// Depends on b2dasc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b2dasc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input b2dasc_pkg::req_t in_req_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input b2dasc_pkg::rsp_t out_rsp_o
);

  // Hold a stalled response
  `B2D_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o), "response dropped or changed while stalled")

  // Drop valid only after the response was taken
  `B2D_ASSERT(a_out_fall, $fell(out_valid_o) |-> $past(out_ready_i), "response withdrawn before accept")

  // Every character is a decimal digit
  `B2D_ASSERT(a_char_range, out_valid_o |-> (out_rsp_o.character >= 6'd48) && (out_rsp_o.character <= 6'd57), "character outside '0'..'9'")

  // Go busy right after taking a request
  `B2D_ASSERT(a_busy_after_req, in_valid_i && in_ready_o |=> !in_ready_o, "ready stayed high after a request was taken")

endmodule

bind binary_to_decimal_ascii_top b2dasc_checker u_b2dasc_checker (.*);
